[rtl/cbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared widths, defaults, register indexes and the control/status bundles
// between the cell balance selector controller and datapath.
// ----------------------------------------------------------------------------
package cbs_pkg;

	localparam int MV_W          = 16;
	localparam int GROUP_IDX_W   = 2;
	localparam int MASK_W        = 5;
	localparam int CFG_IDX_W     = 1;

	localparam int DEF_CELLS_PER_GROUP = 5;
	localparam int DEF_GROUP_COUNT     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BALANCE_OFFSET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BALANCE_FLOOR  = 1'b1;

	typedef struct packed {
		logic load;
		logic prep;
		logic grp_init;
		logic pass_init;
		logic scan;
		logic decide;
		logic next_group;
	} cbs_cmd_t;

	typedef struct packed {
		logic pack_last;
		logic scan_end;
		logic found;
		logic last_group;
	} cbs_status_t;

endpackage

`default_nettype wire

[rtl/cbs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_ctrl
// Sequencer: collects cells, then walks groups, selection passes and the
// per-pass scan over the cell memory, and hands each group mask out.
// ----------------------------------------------------------------------------
module cbs_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire                  out_stall,
	input  cbs_pkg::cbs_status_t status,
	output cbs_pkg::cbs_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_COLLECT = 7'b0000001,
		ST_PREP    = 7'b0000010,
		ST_GRP     = 7'b0000100,
		ST_PASS    = 7'b0001000,
		ST_SCAN    = 7'b0010000,
		ST_DECIDE  = 7'b0100000,
		ST_EMIT    = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_COLLECT: begin
				cmd.load = in_valid;
				if (in_valid && status.pack_last) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_GRP;
			end
			ST_GRP: begin
				cmd.grp_init = 1'b1;
				state_d      = ST_PASS;
			end
			ST_PASS: begin
				cmd.pass_init = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				// last compare lands on this edge
				if (status.scan_end) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.found) begin
					cmd.decide = 1'b1;
					state_d    = ST_PASS;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_stall) begin
					cmd.next_group = 1'b1;
					state_d        = status.last_group ? ST_COLLECT : ST_GRP;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_COLLECT);
	assign out_valid = (state_q == ST_EMIT);

endmodule

`default_nettype wire

[rtl/cbs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_datapath
// Cell memory, running pack min/max, config registers, one-cell-per-cycle
// scan for the highest free cell, exclusion vector and group mask.
// ----------------------------------------------------------------------------
module cbs_datapath #(
	parameter int CELLS_PER_GROUP = cbs_pkg::DEF_CELLS_PER_GROUP,
	parameter int GROUP_COUNT     = cbs_pkg::DEF_GROUP_COUNT
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  cbs_pkg::cbs_cmd_t                  cmd,
	output cbs_pkg::cbs_status_t               status,
	input  wire  [cbs_pkg::MV_W-1:0]           cell_mv,
	input  wire                                cfg_we,
	input  wire  [cbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [cbs_pkg::MV_W-1:0]           cfg_data,
	output logic [cbs_pkg::GROUP_IDX_W-1:0]    group_id,
	output logic [cbs_pkg::MASK_W-1:0]         balance_mask,
	output logic [cbs_pkg::MV_W-1:0]           pack_min_mv,
	output logic [cbs_pkg::MV_W-1:0]           pack_max_mv,
	output logic                               balance_done,
	output logic                               last_group
);

	localparam int TOTAL = CELLS_PER_GROUP * GROUP_COUNT;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int PW    = $clog2(CELLS_PER_GROUP);
	localparam int KW    = $clog2(CELLS_PER_GROUP + 1);
	localparam int GW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int MV    = cbs_pkg::MV_W;

	logic [MV-1:0]              mem [TOTAL];
	logic [AW-1:0]              wr_ptr_q;
	logic [MV-1:0]              min_q, max_q;
	logic [MV-1:0]              offset_q, floor_q;
	logic [MV:0]                mpo_q;
	logic                       done_q;
	logic [GW-1:0]              group_q;
	logic [AW-1:0]              base_q;
	logic [KW-1:0]              k_q;
	logic [AW-1:0]              rd_addr;
	logic [MV-1:0]              rd_data_s1;
	logic [PW-1:0]              rd_pos_s1;
	logic                       rd_vld_s1;
	logic                       found_q;
	logic [MV-1:0]              best_mv_q;
	logic [PW-1:0]              best_pos_q;
	logic [CELLS_PER_GROUP-1:0] excl_q, excl_next;
	logic [CELLS_PER_GROUP-1:0] mask_q;
	logic                       read_en;
	logic [7:0]                 grp_wide, mask_wide;
	logic [MV-1:0]              min_next, max_next;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			floor_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cbs_pkg::REG_BALANCE_OFFSET: offset_q <= cfg_data;
				cbs_pkg::REG_BALANCE_FLOOR:  floor_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// cell memory: write on input transfer, registered read during scan
	assign read_en = cmd.scan && (k_q < KW'(CELLS_PER_GROUP));
	assign rd_addr = base_q + AW'(k_q[PW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[wr_ptr_q] <= cell_mv;
		end
		if (read_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		rd_pos_s1 <= k_q[PW-1:0];
	end

	assign min_next = (wr_ptr_q == '0 || cell_mv < min_q) ? cell_mv : min_q;
	assign max_next = (wr_ptr_q == '0 || cell_mv > max_q) ? cell_mv : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
		end else if (cmd.load) begin
			wr_ptr_q <= (wr_ptr_q == AW'(TOTAL - 1)) ? '0 : wr_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			min_q <= min_next;
			max_q <= max_next;
		end
		if (cmd.prep) begin
			mpo_q  <= {1'b0, min_q} + {1'b0, offset_q};
			done_q <= (max_q < floor_q) || ({1'b0, max_q} < ({1'b0, min_q} + {1'b0, offset_q}));
		end
	end

	// group walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			base_q  <= '0;
		end else if (cmd.prep) begin
			group_q <= '0;
			base_q  <= '0;
		end else if (cmd.next_group) begin
			group_q <= group_q + 1'b1;
			base_q  <= base_q + AW'(CELLS_PER_GROUP);
		end
	end

	// scan counter and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= read_en;
			if (cmd.pass_init) begin
				k_q     <= '0;
				found_q <= 1'b0;
			end else begin
				if (read_en) begin
					k_q <= k_q + 1'b1;
				end
				if (rd_vld_s1 && !excl_q[rd_pos_s1] &&
					(!found_q || rd_data_s1 > best_mv_q)) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// strict greater keeps the earlier cell on a tie
	always_ff @(posedge clk) begin
		if (!cmd.pass_init && rd_vld_s1 && !excl_q[rd_pos_s1] &&
			(!found_q || rd_data_s1 > best_mv_q)) begin
			best_mv_q  <= rd_data_s1;
			best_pos_q <= rd_pos_s1;
		end
	end

	// picked cell and its in-group neighbors
	always_comb begin
		for (int i = 0; i < CELLS_PER_GROUP; i++) begin
			excl_next[i] = excl_q[i] ||
				({1'b0, best_pos_q} == (PW+1)'(i)) ||
				(({1'b0, best_pos_q} + 1'b1) == (PW+1)'(i)) ||
				({1'b0, best_pos_q} == (PW+1)'(i + 1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.grp_init) begin
			excl_q <= '0;
			mask_q <= '0;
		end else if (cmd.decide) begin
			excl_q <= excl_next;
			if (({1'b0, best_mv_q} > mpo_q) && (best_mv_q > floor_q)) begin
				mask_q[best_pos_q] <= 1'b1;
			end
		end
	end

	assign status.pack_last  = (wr_ptr_q == AW'(TOTAL - 1));
	assign status.scan_end   = (k_q == KW'(CELLS_PER_GROUP));
	assign status.found      = found_q;
	assign status.last_group = (group_q == GW'(GROUP_COUNT - 1));

	assign grp_wide     = 8'(group_q);
	assign mask_wide    = 8'(mask_q);
	assign group_id     = grp_wide[cbs_pkg::GROUP_IDX_W-1:0];
	assign balance_mask = mask_wide[cbs_pkg::MASK_W-1:0];
	assign pack_min_mv  = min_q;
	assign pack_max_mv  = max_q;
	assign balance_done = done_q;
	assign last_group   = status.last_group;

endmodule

`default_nettype wire

[rtl/cell_balance_selector.sv]
// cells are taken one per cycle; the pack's last cell is followed by a prep step, then
// per group a group init, one pass (pass init, scan, decide) per pick plus a final pass
//   that finds no cell, and the mask transfer; each pass reads one cell from memory per cycle
// no new cell is taken until the last group mask of the pack has transferred
// asynchronous active-low reset clears control state and both config registers
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cell_balance_selector
// Collects a pack of cell voltages and emits one balancing mask per group of
// adjacent cells, with pack min/max and a balancing-complete flag.
// ----------------------------------------------------------------------------
module cell_balance_selector #(
	parameter int CELLS_PER_GROUP = cbs_pkg::DEF_CELLS_PER_GROUP,
	parameter int GROUP_COUNT     = cbs_pkg::DEF_GROUP_COUNT
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [cbs_pkg::MV_W-1:0]           cell_mv,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [cbs_pkg::GROUP_IDX_W-1:0]    group_id,
	output logic [cbs_pkg::MASK_W-1:0]         balance_mask,
	output logic [cbs_pkg::MV_W-1:0]           pack_min_mv,
	output logic [cbs_pkg::MV_W-1:0]           pack_max_mv,
	output logic                               balance_done,
	output logic                               last_group,
	input  wire                                cfg_we,
	input  wire  [cbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [cbs_pkg::MV_W-1:0]           cfg_data
);

	cbs_pkg::cbs_cmd_t    cmd;
	cbs_pkg::cbs_status_t status;

	cbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	cbs_datapath #(
		.CELLS_PER_GROUP (CELLS_PER_GROUP),
		.GROUP_COUNT     (GROUP_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cell_mv      (cell_mv),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.group_id     (group_id),
		.balance_mask (balance_mask),
		.pack_min_mv  (pack_min_mv),
		.pack_max_mv  (pack_max_mv),
		.balance_done (balance_done),
		.last_group   (last_group)
	);

endmodule

`default_nettype wire

[tb/cell_balance_selector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_balance_selector_tb
// Feeds whole packs of cell voltages into the selector and checks every group
// mask and pack summary against a local model of the selection. A short table
// of hand-worked packs comes first, then random packs under changing
// thresholds and changing handshake pressure.
// ----------------------------------------------------------------------------
module cell_balance_selector_tb;

	localparam int MV_W        = cbs_pkg::MV_W;
	localparam int GROUP_IDX_W = cbs_pkg::GROUP_IDX_W;
	localparam int MASK_W      = cbs_pkg::MASK_W;
	localparam int CFG_IDX_W   = cbs_pkg::CFG_IDX_W;

	localparam int CPG         = cbs_pkg::DEF_CELLS_PER_GROUP;
	localparam int GROUPS      = cbs_pkg::DEF_GROUP_COUNT;
	localparam int TOTAL       = CPG * GROUPS;
	localparam int PACKS_PER_PHASE = 3;
	localparam int SETTLE_CYCLES   = 200;
	localparam int HOLD_CYCLES     = 400;
	localparam int MAX_REPORTS     = 10;
	localparam int TIMEOUT_NS      = 400000;

	typedef struct packed {
		logic [GROUP_IDX_W-1:0] grp;
		logic [MASK_W-1:0]      mask;
		logic [MV_W-1:0]        mn;
		logic [MV_W-1:0]        mx;
		logic                   done;
		logic                   last;
	} group_result_t;

	typedef struct packed {
		logic                          write_cfg;
		logic [MV_W-1:0]               offset;
		logic [MV_W-1:0]               floor_mv;
		logic [TOTAL-1:0][MV_W-1:0]    cells;
		logic [GROUPS-1:0][MASK_W-1:0] masks;
		logic [MV_W-1:0]               mn;
		logic [MV_W-1:0]               mx;
		logic                          done;
	} hand_pack_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MV_W-1:0] cell_mv = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [GROUP_IDX_W-1:0] group_id;
	logic [MASK_W-1:0] balance_mask;
	logic [MV_W-1:0] pack_min_mv;
	logic [MV_W-1:0] pack_max_mv;
	logic balance_done;
	logic last_group;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = cbs_pkg::REG_BALANCE_OFFSET;
	logic [MV_W-1:0] cfg_data = '0;

	// local copy of the block state
	logic [MV_W-1:0] pack_mv [TOTAL];
	int fill_cnt = 0;
	logic [MV_W-1:0] cur_offset = '0;
	logic [MV_W-1:0] cur_floor = '0;
	group_result_t group_q [$];

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	bit pressure_on = 1'b0;
	int hold_cnt = 0;
	int err_cnt = 0;
	int packs_in = 0;
	int groups_seen = 0;
	int bleed_groups = 0;
	int done_groups = 0;
	int settings_cnt = 0;

	hand_pack_t pack_tbl [2];

	cell_balance_selector u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cell_mv      (cell_mv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.group_id     (group_id),
		.balance_mask (balance_mask),
		.pack_min_mv  (pack_min_mv),
		.pack_max_mv  (pack_max_mv),
		.balance_done (balance_done),
		.last_group   (last_group),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// store one cell; on the last cell of a pack work out all group results
	function automatic void collect_cell(input logic [MV_W-1:0] mv);
		logic [MV_W-1:0] mn;
		logic [MV_W-1:0] mx;
		logic [MV_W-1:0] best_mv;
		logic [MV_W:0] min_off;
		logic [TOTAL-1:0] excl;
		logic done;
		int best;
		int first;
		int lastc;
		bit found;
		group_result_t r;
		pack_mv[fill_cnt] = mv;
		fill_cnt++;
		if (fill_cnt < TOTAL)
			return;
		fill_cnt = 0;
		packs_in++;
		mn = '1;
		mx = '0;
		excl = '0;
		for (int i = 0; i < TOTAL; i++) begin
			if (pack_mv[i] < mn)
				mn = pack_mv[i];
			if (pack_mv[i] > mx)
				mx = pack_mv[i];
		end
		// 17-bit sum, a cell can never exceed a sum past full scale
		min_off = {1'b0, mn} + {1'b0, cur_offset};
		done = (mx < cur_floor) || ({1'b0, mx} < min_off);
		best_mv = '0;
		best = 0;
		for (int g = 0; g < GROUPS; g++) begin
			first = g * CPG;
			lastc = first + CPG - 1;
			r.grp = GROUP_IDX_W'(g);
			r.mask = '0;
			r.mn = mn;
			r.mx = mx;
			r.done = done;
			r.last = (g == GROUPS - 1);
			found = 1'b1;
			while (found) begin
				found = 1'b0;
				// strict compare keeps the earlier cell on a tie
				for (int i = first; i <= lastc; i++) begin
					if (!excl[i] && (!found || pack_mv[i] > best_mv)) begin
						found = 1'b1;
						best = i;
						best_mv = pack_mv[i];
					end
				end
				if (found) begin
					if ({1'b0, best_mv} > min_off && best_mv > cur_floor)
						r.mask[best - first] = 1'b1;
					excl[best] = 1'b1;
					if (best < lastc)
						excl[best + 1] = 1'b1;
					if (best > first)
						excl[best - 1] = 1'b1;
				end
			end
			group_q.push_back(r);
		end
	endfunction

	function automatic logic [MV_W-1:0] next_cell(input logic [MV_W-1:0] prev);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 4)
			return '0;
		if (pick < 8)
			return '1;
		if (pick < 16)
			return MV_W'($urandom);
		if (pick < 30)
			return prev;
		return MV_W'(2800 + $urandom_range(1400));
	endfunction

	task automatic send_cell(input logic [MV_W-1:0] mv);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cell_mv <= mv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		collect_cell(mv);
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == cbs_pkg::REG_BALANCE_OFFSET)
			cur_offset = val;
		else
			cur_floor = val;
	endtask

	task automatic write_thresholds(input logic [MV_W-1:0] off, input logic [MV_W-1:0] flr);
		write_reg(cbs_pkg::REG_BALANCE_OFFSET, off);
		write_reg(cbs_pkg::REG_BALANCE_FLOOR, flr);
		settings_cnt++;
	endtask

	task automatic wait_drain();
		while (group_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			err_cnt++;
			if (err_cnt <= MAX_REPORTS)
				$display("mismatch %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
		end
	endtask

	// receiver: random stall, plus one long hold-off so the block backs up
	always @(negedge clk) begin
		if (pressure_on && hold_cnt < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_cnt++;
		end else begin
			out_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	always @(posedge clk) begin
		group_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (group_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("unexpected group mask transfer: group %0d mask %0d at %0t",
						group_id, balance_mask, $realtime);
			end else begin
				want = group_q.pop_front();
				check_field("group_id", want.grp, group_id);
				check_field("balance_mask", want.mask, balance_mask);
				check_field("pack_min_mv", want.mn, pack_min_mv);
				check_field("pack_max_mv", want.mx, pack_max_mv);
				check_field("balance_done", want.done, balance_done);
				check_field("last_group", want.last, last_group);
				groups_seen++;
				if (want.mask != '0)
					bleed_groups++;
				if (want.done)
					done_groups++;
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [MV_W-1:0] prev;
		group_result_t r;
		logic [MV_W-1:0] off;
		logic [MV_W-1:0] flr;

		// reset thresholds; full-scale, empty and alternating groups
		// cells listed from cell 14 down to cell 0
		pack_tbl[0].write_cfg = 1'b0;
		pack_tbl[0].offset = '0;
		pack_tbl[0].floor_mv = '0;
		pack_tbl[0].cells = {16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0,
			16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535};
		pack_tbl[0].masks = {5'd10, 5'd0, 5'd21};
		pack_tbl[0].mn = 16'd0;
		pack_tbl[0].mx = 16'd65535;
		pack_tbl[0].done = 1'b0;
		// full-scale thresholds: min plus offset passes 65535, nothing bleeds
		pack_tbl[1].write_cfg = 1'b1;
		pack_tbl[1].offset = 16'd65535;
		pack_tbl[1].floor_mv = 16'd65535;
		pack_tbl[1].cells = {16'd4, 16'd9999, 16'd3, 16'd65535, 16'd500,
			16'd7, 16'd65535, 16'd1, 16'd12345, 16'd65534,
			16'd32768, 16'd40000, 16'd2, 16'd65535, 16'd1};
		pack_tbl[1].masks = '0;
		pack_tbl[1].mn = 16'd1;
		pack_tbl[1].mx = 16'd65535;
		pack_tbl[1].done = 1'b1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settings_cnt = 1;

		for (int t = 0; t < 2; t++) begin
			wait_drain();
			if (pack_tbl[t].write_cfg)
				write_thresholds(pack_tbl[t].offset, pack_tbl[t].floor_mv);
			for (int i = 0; i < TOTAL; i++)
				send_cell(pack_tbl[t].cells[i]);
			// hand-worked values stand in for the predicted ones
			repeat (GROUPS) void'(group_q.pop_back());
			for (int g = 0; g < GROUPS; g++) begin
				r.grp = GROUP_IDX_W'(g);
				r.mask = pack_tbl[t].masks[g];
				r.mn = pack_tbl[t].mn;
				r.mx = pack_tbl[t].mx;
				r.done = pack_tbl[t].done;
				r.last = (g == GROUPS - 1);
				group_q.push_back(r);
			end
			end_burst();
		end

		prev = 16'd3500;
		for (int ph = 0; ph < 3; ph++) begin
			wait_drain();
			case (ph)
				0: begin
					in_idle_pct = 32;
					out_idle_pct = 64;
					off = MV_W'($urandom_range(400));
					flr = MV_W'(2800 + $urandom_range(1200));
				end
				1: begin
					in_idle_pct = 64;
					out_idle_pct = 32;
					off = MV_W'($urandom_range(100));
					flr = MV_W'($urandom_range(3400));
				end
				default: begin
					in_idle_pct = 0;
					out_idle_pct = 0;
					off = MV_W'($urandom_range(300));
					flr = MV_W'(3000 + $urandom_range(800));
				end
			endcase
			write_thresholds(off, flr);
			if (ph == 2)
				pressure_on = 1'b1;
			for (int p = 0; p < PACKS_PER_PHASE; p++) begin
				for (int i = 0; i < TOTAL; i++) begin
					prev = next_cell(prev);
					send_cell(prev);
				end
			end
			end_burst();
		end
		wait_drain();

		$display("run covered %0d packs and %0d group masks under %0d threshold settings",
			packs_in, groups_seen, settings_cnt);
		$display("%0d masks with bleeding cells, %0d with balancing complete, %0d errors",
			bleed_groups, done_groups, err_cnt);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[cell_balance_selector.f]
rtl/cbs_pkg.sv
rtl/cbs_ctrl.sv
rtl/cbs_datapath.sv
rtl/cell_balance_selector.sv
tb/cell_balance_selector_tb.sv
